[rtl/pmid_pkg.sv]
// Shared types and constants for the periodic minimum-image distance block.
package pmid_pkg;

  // Default coordinate width (signed, fixed point).
  localparam int COORD_BITS_DEF = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z_LOW  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z_HIGH = 3'd5;

  // Control that travels along the square-root chain with each transfer.
  typedef struct packed {
    logic vld;  // stage holds a live item
    logic sat;  // sum of squares reached the cap, force full-scale result
  } ctl_t;

endpackage

[rtl/pmid_axis.sv]
// One axis: minimum-image gap and its square, four register stages.
module pmid_axis #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic signed [COORD_BITS-1:0] coord_a,
  input  logic signed [COORD_BITS-1:0] coord_b,
  input  logic signed [COORD_BITS-1:0] box_low,
  input  logic signed [COORD_BITS-1:0] box_high,
  output logic [2*COORD_BITS+1:0]     dist_sq
);
  import pmid_pkg::*;

  localparam int W = COORD_BITS;

  logic signed [W:0]   ab_diff, ba_diff, len_nxt, gap_nxt;
  logic signed [W:0]   gap_r, len_r;
  logic signed [W+1:0] wrapped, d_nxt, d_r;
  logic signed [W+1:0] d_neg;
  logic [W:0]          mag_nxt, mag_r;
  logic [2*W+1:0]      sq_nxt, sq_r;

  // Stage 1: plain gap as |a - b|, box length.
  always_comb begin
    ab_diff = {coord_a[W-1], coord_a} - {coord_b[W-1], coord_b};
    ba_diff = {coord_b[W-1], coord_b} - {coord_a[W-1], coord_a};
    gap_nxt = ab_diff[W] ? ba_diff : ab_diff;
    len_nxt = {box_high[W-1], box_high} - {box_low[W-1], box_low};
  end

  // Stage 2: wrapped gap and signed minimum.
  always_comb begin
    wrapped = {len_r[W], len_r} - {gap_r[W], gap_r};
    d_nxt   = ($signed({gap_r[W], gap_r}) < wrapped) ? {gap_r[W], gap_r} : wrapped;
  end

  // Stage 3: magnitude; it always fits in W+1 bits.
  always_comb begin
    d_neg   = -d_r;
    mag_nxt = d_r[W+1] ? d_neg[W:0] : d_r[W:0];
  end

  // Stage 4: square.
  assign sq_nxt = (2*W+2)'(mag_r) * (2*W+2)'(mag_r);

  always_ff @(posedge clk) begin
    gap_r <= gap_nxt;
    len_r <= len_nxt;
    d_r   <= d_nxt;
    mag_r <= mag_nxt;
    sq_r  <= sq_nxt;
  end

  assign dist_sq = sq_r;

endmodule

[rtl/pmid_sqrt_cell.sv]
// One digit cell of the pipelined square root: one result bit per cell.
module pmid_sqrt_cell #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pmid_pkg::ctl_t           ctl_i,
  input  logic [2*COORD_BITS+1:0]  rad_i,
  input  logic [COORD_BITS:0]      root_i,
  input  logic [COORD_BITS+2:0]    rem_i,
  output pmid_pkg::ctl_t           ctl_o,
  output logic [2*COORD_BITS+1:0]  rad_o,
  output logic [COORD_BITS:0]      root_o,
  output logic [COORD_BITS+2:0]    rem_o
);
  import pmid_pkg::*;

  localparam int RB   = COORD_BITS + 1;
  localparam int RADB = 2*COORD_BITS + 2;
  localparam int REMB = COORD_BITS + 3;

  ctl_t            ctl_r;
  logic [RADB-1:0] rad_r, rad_nxt;
  logic [RB-1:0]   root_r, root_nxt;
  logic [REMB-1:0] rem_r, rem_nxt;
  logic [REMB-1:0] cat;
  logic [REMB:0]   diff;
  logic            ge;

  // Bring down two radicand bits, try subtracting 4*root + 1.
  always_comb begin
    cat      = {rem_i[REMB-3:0], rad_i[RADB-1 -: 2]};
    diff     = {1'b0, cat} - {1'b0, root_i, 2'b01};
    ge       = !diff[REMB];
    rem_nxt  = ge ? diff[REMB-1:0] : cat;
    root_nxt = {root_i[RB-2:0], ge};
    rad_nxt  = {rad_i[RADB-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

[rtl/periodic_min_image_distance.sv]
// Top level: minimum-image distance of two 3-D points in a periodic box.
//
//  channel | ports                               | direction | flow control
//  --------+-------------------------------------+-----------+------------------------
//  input   | start, busy, in_first_*, in_second_* | in        | transfer on start & !busy
//  result  | out_valid, out_separation           | out       | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data         | in        | write on cfg_we, no wait
//
//  A new pair is taken in every cycle; busy stays low. Between a transfer and
//  its result lie four stages per axis (gap, minimum, magnitude, square), one
//  sum stage, a chain of COORD_BITS + 1 square-root cells (one root bit each)
//  and an output register. rst_n is synchronous, clears all valid bits and
//  returns the box registers to their defaults; data in flight is dropped. The
//  receiver cannot stall, so the pipeline never holds.
module periodic_min_image_distance #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         in_first_x,
  input  logic signed [COORD_BITS-1:0]         in_first_y,
  input  logic signed [COORD_BITS-1:0]         in_first_z,
  input  logic signed [COORD_BITS-1:0]         in_second_x,
  input  logic signed [COORD_BITS-1:0]         in_second_y,
  input  logic signed [COORD_BITS-1:0]         in_second_z,
  output logic                                 out_valid,
  output logic [COORD_BITS:0]                  out_separation,
  input  logic                                 cfg_we,
  input  logic [pmid_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data
);
  import pmid_pkg::*;

  localparam int W       = COORD_BITS;
  localparam int RB      = W + 1;
  localparam int RADB    = 2*W + 2;
  localparam int REMB    = W + 3;
  localparam int SUMB    = 2*W + 4;
  localparam int NCELL   = W + 1;
  localparam int FRONT   = 4;
  localparam int LATENCY = W + 7;

  // Box edge registers; the upper edge resets to the largest coordinate.
  logic signed [W-1:0] x_low_r, x_high_r, y_low_r, y_high_r, z_low_r, z_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= {1'b0, {(W-1){1'b1}}};
      y_low_r  <= '0;
      y_high_r <= {1'b0, {(W-1){1'b1}}};
      z_low_r  <= '0;
      z_high_r <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X_LOW:  x_low_r  <= cfg_data;
        REG_BOX_X_HIGH: x_high_r <= cfg_data;
        REG_BOX_Y_LOW:  y_low_r  <= cfg_data;
        REG_BOX_Y_HIGH: y_high_r <= cfg_data;
        REG_BOX_Z_LOW:  z_low_r  <= cfg_data;
        REG_BOX_Z_HIGH: z_high_r <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Every cycle is open for a transfer.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // Per-axis front end.
  logic [RADB-1:0] sq_x, sq_y, sq_z;

  pmid_axis #(.COORD_BITS(W)) u_axis_x (
    .clk(clk), .coord_a(in_first_x), .coord_b(in_second_x),
    .box_low(x_low_r), .box_high(x_high_r), .dist_sq(sq_x)
  );
  pmid_axis #(.COORD_BITS(W)) u_axis_y (
    .clk(clk), .coord_a(in_first_y), .coord_b(in_second_y),
    .box_low(y_low_r), .box_high(y_high_r), .dist_sq(sq_y)
  );
  pmid_axis #(.COORD_BITS(W)) u_axis_z (
    .clk(clk), .coord_a(in_first_z), .coord_b(in_second_z),
    .box_low(z_low_r), .box_high(z_high_r), .dist_sq(sq_z)
  );

  // Track valid through the axis stages.
  logic [FRONT-1:0] front_vld_r, front_vld_nxt;
  assign front_vld_nxt = {front_vld_r[FRONT-2:0], in_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= '0;
    end else begin
      front_vld_r <= front_vld_nxt;
    end
  end

  // Sum stage. Each square is below the cap, so one check on the total
  // covers the saturating adds; a saturated sum maps to full scale.
  logic [SUMB-1:0] sum_nxt;
  logic [RADB-1:0] rad_r;
  ctl_t            sum_ctl_r, sum_ctl_nxt;

  always_comb begin
    sum_nxt         = SUMB'(sq_x) + SUMB'(sq_y) + SUMB'(sq_z);
    sum_ctl_nxt.vld = front_vld_r[FRONT-1];
    sum_ctl_nxt.sat = |sum_nxt[SUMB-1:RADB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_ctl_r <= '0;
    end else begin
      sum_ctl_r <= sum_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= sum_nxt[RADB-1:0];
  end

  // Square-root chain: each cell resolves one root bit and passes on.
  ctl_t            chain_ctl  [NCELL+1];
  logic [RADB-1:0] chain_rad  [NCELL+1];
  logic [RB-1:0]   chain_root [NCELL+1];
  logic [REMB-1:0] chain_rem  [NCELL+1];

  assign chain_ctl[0]  = sum_ctl_r;
  assign chain_rad[0]  = rad_r;
  assign chain_root[0] = '0;
  assign chain_rem[0]  = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    pmid_sqrt_cell #(.COORD_BITS(W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl_i(chain_ctl[k]), .rad_i(chain_rad[k]),
      .root_i(chain_root[k]), .rem_i(chain_rem[k]),
      .ctl_o(chain_ctl[k+1]), .rad_o(chain_rad[k+1]),
      .root_o(chain_root[k+1]), .rem_o(chain_rem[k+1])
    );
  end

  // Output register: saturate to full scale when flagged.
  logic          out_valid_r;
  logic [RB-1:0] out_sep_r, out_sep_nxt;

  assign out_sep_nxt = chain_ctl[NCELL].sat ? {RB{1'b1}} : chain_root[NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_ctl[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_sep_r <= out_sep_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_separation = out_sep_r;

`ifndef SYNTHESIS
  // Every transfer yields a matching result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##LATENCY out_valid)
    else $error("result strobe missing after input transfer");

  // No strobe without a matching earlier transfer.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, LATENCY))
    else $error("result strobe without matching input transfer");

  // A saturated sum leaves the chain as full scale.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_ctl[NCELL].vld && chain_ctl[NCELL].sat)
      |=> (out_valid && out_separation == {RB{1'b1}}))
    else $error("saturated sum not driven to full scale");
`endif

endmodule
